/* rtl/ptc_pkg.sv */
// Shared types and constants for the pressure/temperature compensation block.
// Holds the calibration bundle, the queue entry layout and register indexes.
// No dependencies.
package ptc_pkg;

	// Register indexes on the configuration port
	localparam logic [7:0] REG_TEMP_CAL   = 8'd0;
	localparam logic [7:0] REG_PRESS_LOW  = 8'd1;
	localparam logic [7:0] REG_PRESS_HIGH = 8'd2;
	localparam logic [7:0] REG_PRESS_NINE = 8'd3;

	// Fixed constants of the compensation formulas
	localparam logic [32:0] TEMP_OFFSET      = 33'd128000;
	localparam logic [20:0] PRESS_FULL_SCALE = 21'd1048576;
	localparam logic [63:0] VAR1_BIAS        = 64'h0000_8000_0000_0000;
	localparam logic [63:0] PRESS_SCALE      = 64'd3125;
	localparam logic [63:0] TRUNC_BIAS       = 64'd255;

	// Divider length (one quotient bit per stage) and queue sizing
	localparam int unsigned DIV_STEPS = 64;
	localparam int unsigned Q_DEPTH   = 4;
	localparam int unsigned Q_AW      = 2;

	// Unpacked calibration words
	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic        [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} cal_t;

	// One entry between front and back: temperature results plus division operands
	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] fine;
		logic [63:0] num;
		logic [30:0] den;
		logic        zero;
	} item_t;

endpackage

/* rtl/ptc_front.sv */
// Front pipeline: temperature compensation and pressure var1/var2 terms.
// Produces the division operands and the zero-divisor class per beat.
// Depends on ptc_pkg.
module ptc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  ptc_pkg::cal_t  cal,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [19:0]    raw_pressure,
	input  logic [19:0]    raw_temperature,
	input  logic           q_full,
	output logic           push,
	output ptc_pkg::item_t item
);

	logic        adv;
	logic [12:1] vld_q;

	logic [19:0] adcp_s [1:9];
	logic [19:0] adct_s1;
	logic [31:0] ma_s2, mb_s2;
	logic [31:0] tv1_s3, mc_s3;
	logic [31:0] fine_s [4:11];
	logic [31:0] temp_s [5:11];
	logic signed [32:0] v1_s5;
	logic [63:0] sq_s6;
	logic signed [48:0] m5_s6, m2_s6, m5_s7, m2_s7, m5_s8, m2_s8;
	logic signed [48:0] pp6lo_s7, pp3lo_s7;
	logic [31:0] pp6hi_s7, pp3hi_s7;
	logic [63:0] q6_s8, q3_s8;
	logic [63:0] v2_s9, v1b_s9;
	logic [63:0] x_s10, dn_s10;
	logic [47:0] xlo_s11;
	logic [31:0] xhi_s11;
	logic [63:0] num_s11;
	ptc_pkg::item_t item_s12;

	logic [31:0] t2x, t3x, p6x, p3x;
	logic [31:0] a_c, b_c, tv1_c, c_c, tv2_c, scaled_c, temp_c;
	logic signed [65:0] sq_c;
	logic [63:0] q3sh_c, prod_c;
	logic [20:0] pd_c;

	// Whole front moves unless the finished beat cannot enter the queue
	assign adv      = !(vld_q[12] && q_full);
	assign in_ready = adv;
	assign push     = vld_q[12] && !q_full;
	assign item     = item_s12;

	assign t2x = {{16{cal.t2[15]}}, cal.t2};
	assign t3x = {{16{cal.t3[15]}}, cal.t3};
	assign p6x = {{16{cal.p6[15]}}, cal.p6};
	assign p3x = {{16{cal.p3[15]}}, cal.p3};

	// Temperature terms, 32-bit wrapping
	assign a_c      = {15'd0, adct_s1[19:3]} - {15'd0, cal.t1, 1'b0};
	assign b_c      = {16'd0, adct_s1[19:4]} - {16'd0, cal.t1};
	assign tv1_c    = $signed(ma_s2) >>> 11;
	assign c_c      = $signed(mb_s2) >>> 12;
	assign tv2_c    = $signed(mc_s3) >>> 14;
	assign scaled_c = fine_s[4] * 32'd5 + 32'd128;
	assign temp_c   = $signed(scaled_c) >>> 8;

	// Pressure terms, 64-bit wrapping
	assign sq_c   = v1_s5 * v1_s5;
	assign q3sh_c = $signed(q3_s8) >>> 8;
	assign pd_c   = ptc_pkg::PRESS_FULL_SCALE - {1'b0, adcp_s[9]};
	assign prod_c = {16'd0, xlo_s11} + {xhi_s11, 32'd0};

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[11:1], in_valid};
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		if (adv) begin
			adcp_s[1] <= raw_pressure;
			adct_s1   <= raw_temperature;
			for (int i = 2; i <= 9; i++) begin
				adcp_s[i] <= adcp_s[i-1];
			end

			ma_s2 <= a_c * t2x;
			mb_s2 <= b_c * b_c;

			tv1_s3 <= tv1_c;
			mc_s3  <= c_c * t3x;

			fine_s[4] <= tv1_s3 + tv2_c;
			for (int i = 5; i <= 11; i++) begin
				fine_s[i] <= fine_s[i-1];
			end

			temp_s[5] <= temp_c;
			for (int i = 6; i <= 11; i++) begin
				temp_s[i] <= temp_s[i-1];
			end
			v1_s5 <= $signed({fine_s[4][31], fine_s[4]} - ptc_pkg::TEMP_OFFSET);

			// square and the two linear products
			sq_s6 <= sq_c[63:0];
			m5_s6 <= v1_s5 * $signed(cal.p5);
			m2_s6 <= v1_s5 * $signed(cal.p2);

			// square times P6/P3, split into 32-bit halves
			pp6lo_s7 <= $signed({1'b0, sq_s6[31:0]}) * $signed(cal.p6);
			pp6hi_s7 <= sq_s6[63:32] * p6x;
			pp3lo_s7 <= $signed({1'b0, sq_s6[31:0]}) * $signed(cal.p3);
			pp3hi_s7 <= sq_s6[63:32] * p3x;
			m5_s7    <= m5_s6;
			m2_s7    <= m2_s6;

			q6_s8 <= {{15{pp6lo_s7[48]}}, pp6lo_s7} + {pp6hi_s7, 32'd0};
			q3_s8 <= {{15{pp3lo_s7[48]}}, pp3lo_s7} + {pp3hi_s7, 32'd0};
			m5_s8 <= m5_s7;
			m2_s8 <= m2_s7;

			v2_s9  <= q6_s8 + ({{15{m5_s8[48]}}, m5_s8} << 17)
				+ ({{48{cal.p4[15]}}, cal.p4} << 35);
			v1b_s9 <= q3sh_c + ({{15{m2_s8[48]}}, m2_s8} << 12);

			x_s10  <= v1b_s9 + ptc_pkg::VAR1_BIAS;
			dn_s10 <= ({43'd0, pd_c} << 31) - v2_s9;

			// divisor product split in halves; numerator scale
			xlo_s11 <= x_s10[31:0] * cal.p1;
			xhi_s11 <= x_s10[63:32] * {16'd0, cal.p1};
			num_s11 <= dn_s10 * ptc_pkg::PRESS_SCALE;

			// divisor is the product shifted right by 33; class zero here
			item_s12.temp <= temp_s[11];
			item_s12.fine <= fine_s[11];
			item_s12.num  <= num_s11;
			item_s12.den  <= prod_c[63:33];
			item_s12.zero <= (prod_c[63:33] == 31'd0);
		end
	end

endmodule

/* rtl/ptc_queue.sv */
// Small FIFO between the front and the back pipelines.
// Register-based, depth from ptc_pkg; depends on ptc_pkg.
module ptc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ptc_pkg::item_t wr_item,
	input  logic           pop,
	output ptc_pkg::item_t head,
	output logic           full,
	output logic           empty
);

	logic [ptc_pkg::Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [ptc_pkg::Q_AW:0]   cnt_q;
	ptc_pkg::item_t           mem_q [ptc_pkg::Q_DEPTH];

	assign full  = (cnt_q == (ptc_pkg::Q_AW + 1)'(ptc_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

/* rtl/ptc_back.sv */
// Back pipeline: radix-2 signed divider, P7..P9 correction, final /256, output register.
// Depends on ptc_pkg.
module ptc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ptc_pkg::cal_t      cal,
	input  logic               q_empty,
	input  ptc_pkg::item_t     head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] temperature_centi,
	output logic signed [31:0] fine_temperature,
	output logic        [31:0] pressure_pa,
	output logic               zero_divisor
);

	localparam int unsigned D = ptc_pkg::DIV_STEPS;

	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] fine;
		logic        zero;
	} side_t;

	logic adv;

	// divider stages
	logic [D:0]  dv_vld_q;
	logic [63:0] dv_nq_s   [0:D];
	logic [30:0] dv_rem_s  [0:D-1];
	logic [30:0] dv_da_s   [0:D-1];
	logic        dv_neg_s  [0:D];
	side_t       dv_side_s [0:D];
	logic [31:0] trial_c   [1:D];
	logic [31:0] diff_c    [1:D];
	logic        ge_c      [1:D];

	// post-division stages
	logic [7:1]  ps_vld_q;
	side_t       ps_side_s [1:7];
	logic [63:0] quo_s [1:5];
	logic [63:0] lolo_s2;
	logic [31:0] lohi_s2, p8hi_s2, p9hi_s4;
	logic signed [48:0] p8lo_s2, p9lo_s4;
	logic [63:0] ss_s3, w2_s [3:5], w1_s5, sum_s6, u_s7;

	logic [63:0] sh13_c, pp8_c, w2_c, w_c, w1_c, sh8_c, biased_c, rq_c;
	logic [31:0] p8x, p9x;

	logic        out_vld_q;
	logic [31:0] temp_q, fine_q, press_q;
	logic        zero_q;

	assign adv = !out_vld_q || out_ready;
	assign pop = adv && !q_empty;

	assign out_valid         = out_vld_q;
	assign temperature_centi = temp_q;
	assign fine_temperature  = fine_q;
	assign pressure_pa       = press_q;
	assign zero_divisor      = zero_q;

	// One restoring step per stage
	always_comb begin
		for (int k = 1; k <= D; k++) begin
			trial_c[k] = {dv_rem_s[k-1], dv_nq_s[k-1][63]};
			diff_c[k]  = trial_c[k] - {1'b0, dv_da_s[k-1]};
			ge_c[k]    = (trial_c[k] >= {1'b0, dv_da_s[k-1]});
		end
	end

	assign p8x      = {{16{cal.p8[15]}}, cal.p8};
	assign p9x      = {{16{cal.p9[15]}}, cal.p9};
	assign sh13_c   = $signed(quo_s[1]) >>> 13;
	assign pp8_c    = {{15{p8lo_s2[48]}}, p8lo_s2} + {p8hi_s2, 32'd0};
	assign w2_c     = $signed(pp8_c) >>> 19;
	assign w_c      = {{15{p9lo_s4[48]}}, p9lo_s4} + {p9hi_s4, 32'd0};
	assign w1_c     = $signed(w_c) >>> 25;
	assign sh8_c    = $signed(sum_s6) >>> 8;
	// truncate toward zero: bias negatives before the shift
	assign biased_c = u_s7 + (u_s7[63] ? ptc_pkg::TRUNC_BIAS : 64'd0);
	assign rq_c     = $signed(biased_c) >>> 8;

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_q  <= '0;
			ps_vld_q  <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			dv_vld_q  <= {dv_vld_q[D-1:0], !q_empty};
			ps_vld_q  <= {ps_vld_q[6:1], dv_vld_q[D]};
			out_vld_q <= ps_vld_q[7];
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (adv) begin
			// operand magnitudes and quotient sign
			dv_nq_s[0]   <= head.num[63] ? (64'd0 - head.num) : head.num;
			dv_da_s[0]   <= head.den[30] ? (31'd0 - head.den) : head.den;
			dv_rem_s[0]  <= '0;
			dv_neg_s[0]  <= head.num[63] ^ head.den[30];
			dv_side_s[0] <= '{temp: head.temp, fine: head.fine, zero: head.zero};

			// the last step needs no remainder or divisor after it
			for (int k = 1; k < D; k++) begin
				dv_rem_s[k] <= ge_c[k] ? diff_c[k][30:0] : trial_c[k][30:0];
				dv_da_s[k]  <= dv_da_s[k-1];
			end
			for (int k = 1; k <= D; k++) begin
				dv_nq_s[k]   <= {dv_nq_s[k-1][62:0], ge_c[k]};
				dv_neg_s[k]  <= dv_neg_s[k-1];
				dv_side_s[k] <= dv_side_s[k-1];
			end

			ps_side_s[1] <= dv_side_s[D];
			for (int i = 2; i <= 7; i++) begin
				ps_side_s[i] <= ps_side_s[i-1];
			end
			quo_s[1] <= dv_neg_s[D] ? (64'd0 - dv_nq_s[D]) : dv_nq_s[D];
			for (int i = 2; i <= 5; i++) begin
				quo_s[i] <= quo_s[i-1];
			end

			// s*s and P8*p in 32-bit pieces
			lolo_s2 <= sh13_c[31:0] * sh13_c[31:0];
			lohi_s2 <= sh13_c[31:0] * sh13_c[63:32];
			p8lo_s2 <= $signed({1'b0, quo_s[1][31:0]}) * $signed(cal.p8);
			p8hi_s2 <= quo_s[1][63:32] * p8x;

			ss_s3   <= lolo_s2 + {lohi_s2[30:0], 33'd0};
			w2_s[3] <= w2_c;

			p9lo_s4 <= $signed({1'b0, ss_s3[31:0]}) * $signed(cal.p9);
			p9hi_s4 <= ss_s3[63:32] * p9x;
			w2_s[4] <= w2_s[3];

			w1_s5   <= w1_c;
			w2_s[5] <= w2_s[4];

			sum_s6 <= quo_s[5] + w1_s5 + w2_s[5];

			u_s7 <= sh8_c + ({{48{cal.p7[15]}}, cal.p7} << 4);

			// output register
			temp_q  <= ps_side_s[7].temp;
			fine_q  <= ps_side_s[7].fine;
			zero_q  <= ps_side_s[7].zero;
			press_q <= ps_side_s[7].zero ? 32'd0 : rq_c[31:0];
		end
	end

endmodule

/* rtl/pressure_temp_compensation_unit.sv */
// Top level of the pressure/temperature compensation block.
// Holds the calibration registers; instantiates ptc_front, ptc_queue, ptc_back.
// Depends on ptc_pkg.

// Takes one raw pressure/temperature pair per beat and returns one compensated
// result per beat, in order. Throughput is one pair per clock while the output
// side keeps taking results; out_valid rises once the input beat has passed
// a 12-stage front that does the temperature and polynomial products in
// 32-bit pieces, the queue, 65 divider stages (operand setup plus a 64-step
// radix-2 signed divider, one quotient bit per stage), a 7-stage correction
// after the divider and the output register. A
// 4-entry queue sits between front and back so that output stalls do not reach
// the input for a few beats. Calibration writes take effect at once and must be
// made while no beat is in flight.
module pressure_temp_compensation_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [19:0]        raw_pressure,
	input  logic [19:0]        raw_temperature,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] temperature_centi,
	output logic signed [31:0] fine_temperature,
	output logic        [31:0] pressure_pa,
	output logic               zero_divisor
);

	logic [47:0] temp_cal_q;
	logic [63:0] press_low_q, press_high_q;
	logic [15:0] press_nine_q;

	ptc_pkg::cal_t  cal;
	ptc_pkg::item_t f_item, q_head;
	logic           push, pop, q_full, q_empty;

	assign cfg_ready = 1'b1;

	// Calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q   <= '0;
			press_low_q  <= '0;
			press_high_q <= '0;
			press_nine_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ptc_pkg::REG_TEMP_CAL:   temp_cal_q   <= cfg_data[47:0];
				ptc_pkg::REG_PRESS_LOW:  press_low_q  <= cfg_data;
				ptc_pkg::REG_PRESS_HIGH: press_high_q <= cfg_data;
				ptc_pkg::REG_PRESS_NINE: press_nine_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Unpack the calibration words
	assign cal.t1 = temp_cal_q[15:0];
	assign cal.t2 = temp_cal_q[31:16];
	assign cal.t3 = temp_cal_q[47:32];
	assign cal.p1 = press_low_q[15:0];
	assign cal.p2 = press_low_q[31:16];
	assign cal.p3 = press_low_q[47:32];
	assign cal.p4 = press_low_q[63:48];
	assign cal.p5 = press_high_q[15:0];
	assign cal.p6 = press_high_q[31:16];
	assign cal.p7 = press_high_q[47:32];
	assign cal.p8 = press_high_q[63:48];
	assign cal.p9 = press_nine_q;

	ptc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cal             (cal),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.q_full          (q_full),
		.push            (push),
		.item            (f_item)
	);

	ptc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (f_item),
		.pop     (pop),
		.head    (q_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	ptc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cal               (cal),
		.q_empty           (q_empty),
		.head              (q_head),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.temperature_centi (temperature_centi),
		.fine_temperature  (fine_temperature),
		.pressure_pa       (pressure_pa),
		.zero_divisor      (zero_divisor)
	);

endmodule

/* rtl/ptc_checker.sv */
// Port-level checks for pressure_temp_compensation_unit, with its bind.
// No package dependencies.
module ptc_port_checks (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] temperature_centi,
	input logic signed [31:0] fine_temperature,
	input logic        [31:0] pressure_pa,
	input logic               zero_divisor
);

	logic [31:0]        scaled;
	logic signed [31:0] chk_temp;

	assign scaled   = fine_temperature * 32'd5 + 32'd128;
	assign chk_temp = $signed(scaled) >>> 8;

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pressure_pa)
			&& $stable(temperature_centi) && $stable(fine_temperature)
			&& $stable(zero_divisor))
		else $error("output beat changed while stalled");

	// Result beat leaves only when taken
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("output beat dropped");

	// Zero divisor forces pressure to zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_divisor |-> pressure_pa == 32'd0)
		else $error("pressure nonzero with zero divisor");

	// Temperature follows from the fine temperature in the same beat
	a_temp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature_centi == chk_temp)
		else $error("temperature and fine temperature disagree");

endmodule

bind pressure_temp_compensation_unit ptc_port_checks u_ptc_port_checks (.*);
